// File: src/isfc_pkg.sv
// Shared types and constants for the IPv4 source flow counter.
// Used by isfc_ctrl, isfc_datapath and ipv4_source_flow_counter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isfc_pkg;

   localparam logic [15:0] ETYPE_CVLAN  = 16'h8100;
   localparam logic [15:0] ETYPE_SVLAN  = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [15:0] L2_BASE_LEN  = 16'd14;
   localparam logic [15:0] L2_TAG_LEN   = 16'd18;
   localparam logic [16:0] IPV4_HDR_LEN = 17'd20;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] outer_type;
      logic [15:0] tag_inner_type;
      logic [31:0] source_untagged;
      logic [31:0] source_tagged;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic        counted;
      logic        table_full;
      logic [31:0] flow_key;
      logic [63:0] flow_packets;
      logic [63:0] flow_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [63:0] packets;
      logic [63:0] bytes;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic write;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic ip_flow;
      logic hit;
      logic miss;
      logic full;
   } status_type;

endpackage
`default_nettype wire

// File: src/isfc_ctrl.sv
// Sequencer for the flow counter: classify, scan the table, update, reply.
// Depends on isfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isfc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire isfc_pkg::status_type status,
   output isfc_pkg::cmd_type         cmd
);
   import isfc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (!status.ip_flow) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               state_in = ST_UPDATE;
            end else if (status.miss) begin
               if (status.full) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.write  = 1'b1;
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: src/isfc_datapath.sv
// Header parse, flow table memory, scan pipeline and result register.
// Depends on isfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isfc_datapath #(
   parameter int MAX_FLOWS = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire isfc_pkg::req_type    req_word,
   input  wire isfc_pkg::cmd_type    cmd,
   output isfc_pkg::status_type      status,
   output isfc_pkg::rsp_type         rsp_word,
   output logic                      rsp_strobe
);
   import isfc_pkg::*;

   localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int CW = $clog2(MAX_FLOWS + 1);
   localparam logic [CW-1:0] FILL_MAX = CW'(MAX_FLOWS);

   // Parsed request.
   logic        pass_ff;
   logic        ip_ff;
   logic [31:0] key_ff;
   logic [15:0] add_ff;
   logic        has_tag;
   logic [15:0] l2_len;
   logic [15:0] etype;
   logic        drop;

   always_comb begin
      has_tag = (req_word.outer_type == ETYPE_CVLAN) || (req_word.outer_type == ETYPE_SVLAN);
      l2_len  = has_tag ? L2_TAG_LEN : L2_BASE_LEN;
      etype   = has_tag ? req_word.tag_inner_type : req_word.outer_type;
      drop    = req_word.frame_length < l2_len;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pass_ff <= !drop;
         ip_ff   <= !drop && (etype == ETYPE_IPV4);
         add_ff  <= req_word.frame_length - l2_len;
         if ({1'b0, req_word.frame_length} < ({1'b0, l2_len} + IPV4_HDR_LEN)) begin
            key_ff <= 32'd0;
         end else begin
            key_ff <= has_tag ? req_word.source_tagged : req_word.source_untagged;
         end
      end
   end

   // Flow table. Entries are never removed, so the valid ones are always
   // the first fill_ff entries.
   entry_type       mem [MAX_FLOWS];
   entry_type       rd_data_ff;
   logic [CW-1:0]   fill_ff;
   logic [CW-1:0]   issue_idx_ff;
   logic            cmp_valid_ff;
   logic [AW-1:0]   cmp_idx_ff;
   logic            can_issue;
   logic            hit;
   entry_type       new_entry;
   logic [AW-1:0]   wr_addr;

   assign can_issue = issue_idx_ff < fill_ff;
   assign hit       = cmp_valid_ff && (rd_data_ff.key == key_ff);

   always_comb begin
      status.ip_flow = ip_ff;
      status.hit     = hit;
      status.miss    = !cmp_valid_ff && (issue_idx_ff == fill_ff);
      status.full    = fill_ff == FILL_MAX;
      new_entry.key     = key_ff;
      new_entry.packets = hit ? rd_data_ff.packets + 64'd1 : 64'd1;
      new_entry.bytes   = (hit ? rd_data_ff.bytes : 64'd0) + {48'd0, add_ff};
      wr_addr           = hit ? cmp_idx_ff : fill_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && can_issue) begin
         rd_data_ff <= mem[issue_idx_ff[AW-1:0]];
         cmp_idx_ff <= issue_idx_ff[AW-1:0];
      end
      if (cmd.write) begin
         mem[wr_addr] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         issue_idx_ff <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            issue_idx_ff <= '0;
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_valid_ff <= can_issue;
            if (can_issue) begin
               issue_idx_ff <= issue_idx_ff + CW'(1);
            end
         end
         if (cmd.write && !hit) begin
            fill_ff <= fill_ff + CW'(1);
         end
      end
   end

   // Result register.
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.verdict      <= pass_ff;
         rsp_ff.counted      <= cmd.write;
         rsp_ff.table_full   <= ip_ff && !cmd.write;
         rsp_ff.flow_key     <= ip_ff ? key_ff : 32'd0;
         rsp_ff.flow_packets <= cmd.write ? new_entry.packets : 64'd0;
         rsp_ff.flow_bytes   <= cmd.write ? new_entry.bytes : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_word   = rsp_ff;
   assign rsp_strobe = rsp_valid_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX) else $error("flow table fill count overflow");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe held two cycles");

   a_new_entry_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && !hit) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("new flow did not advance fill count");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && !hit) |-> (fill_ff != FILL_MAX)) else $error("write into full table");

endmodule
`default_nettype wire

// File: src/ipv4_source_flow_counter.sv
// Top level of the IPv4 source-address flow counter.
// Depends on isfc_pkg, isfc_ctrl and isfc_datapath.
//
//   Channel   Ports                     Handshake
//   request   start, busy, req_word     word taken when start is high and busy is low
//   response  rsp_strobe, rsp_word      word valid for the single cycle rsp_strobe is high
//
// An item that is dropped or is not IPv4 is finished from the classify
// state straight into the result register. For an IPv4 item the table
// is searched linearly, one entry per cycle, through the single read
// port of the flow memory, until a hit or the last flow has been read.
// Reset empties the table at once by clearing its fill count; no clearing
// pass is needed. The receiver cannot stall, so the result register is free
// again for the next word as soon as the strobe has been shown.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_source_flow_counter #(
   parameter int MAX_FLOWS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire isfc_pkg::req_type req_word,
   output logic                   rsp_strobe,
   output isfc_pkg::rsp_type      rsp_word
);
   import isfc_pkg::*;

   // The controller sequences each word; the datapath holds the table.
   cmd_type    cmd;
   status_type status;

   isfc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   isfc_datapath #(
      .MAX_FLOWS (MAX_FLOWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

endmodule
`default_nettype wire

// File: tb/ipv4_source_flow_counter_checker.sv
// Checker for the IPv4 source flow counter: watches request and response words,
// predicts each response from its own flow table and compares field by field.
// Depends on isfc_pkg.
`timescale 1ns / 1ps
module ipv4_source_flow_counter_checker #(
   parameter int MAX_FLOWS = 128
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire isfc_pkg::req_type req_word,
   input wire logic              rsp_strobe,
   input wire isfc_pkg::rsp_type rsp_word,
   output int                    fail_count,
   output int                    pending_count
);
   import isfc_pkg::*;

   logic        flow_valid   [MAX_FLOWS];
   logic [31:0] flow_key_tab [MAX_FLOWS];
   logic [63:0] flow_pkts    [MAX_FLOWS];
   logic [63:0] flow_octets  [MAX_FLOWS];
   rsp_type     expected_rsp [$];

   function automatic rsp_type count_frame(req_type f);
      rsp_type r;
      logic [15:0] hdr_len;
      logic [15:0] etype;
      logic [31:0] key;
      int hit;
      int free_idx;
      r = '0;
      hdr_len = L2_BASE_LEN;
      etype = f.outer_type;
      hit = -1;
      free_idx = -1;
      if (f.frame_length < hdr_len) return r;
      if (etype == ETYPE_CVLAN || etype == ETYPE_SVLAN) begin
         hdr_len = L2_TAG_LEN;
         if (f.frame_length < hdr_len) return r;
         etype = f.tag_inner_type;
      end
      r.verdict = 1'b1;
      if (etype != ETYPE_IPV4) return r;
      if ({1'b0, f.frame_length} < {1'b0, hdr_len} + IPV4_HDR_LEN) key = '0;
      else if (hdr_len == L2_BASE_LEN) key = f.source_untagged;
      else key = f.source_tagged;
      r.flow_key = key;
      for (int i = 0; i < MAX_FLOWS; i++) begin
         if (flow_valid[i]) begin
            if (hit < 0 && flow_key_tab[i] == key) hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit >= 0) begin
         flow_pkts[hit]   += 64'd1;
         flow_octets[hit] += 64'(f.frame_length - hdr_len);
      end else if (free_idx >= 0) begin
         hit = free_idx;
         flow_valid[hit]   = 1'b1;
         flow_key_tab[hit] = key;
         flow_pkts[hit]    = 64'd1;
         flow_octets[hit]  = 64'(f.frame_length - hdr_len);
      end else begin
         r.table_full = 1'b1;
         return r;
      end
      r.counted      = 1'b1;
      r.flow_packets = flow_pkts[hit];
      r.flow_bytes   = flow_octets[hit];
      return r;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_FLOWS; i++) flow_valid[i] <= 1'b0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response word %h", rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (want !== rsp_word) fail_count <= fail_count + 1;
               if (want.verdict !== rsp_word.verdict)
                  $error("verdict exp %h got %h", want.verdict, rsp_word.verdict);
               if (want.counted !== rsp_word.counted)
                  $error("counted exp %h got %h", want.counted, rsp_word.counted);
               if (want.table_full !== rsp_word.table_full)
                  $error("table_full exp %h got %h", want.table_full, rsp_word.table_full);
               if (want.flow_key !== rsp_word.flow_key)
                  $error("flow_key exp %h got %h", want.flow_key, rsp_word.flow_key);
               if (want.flow_packets !== rsp_word.flow_packets)
                  $error("flow_packets exp %h got %h", want.flow_packets,
                         rsp_word.flow_packets);
               if (want.flow_bytes !== rsp_word.flow_bytes)
                  $error("flow_bytes exp %h got %h", want.flow_bytes, rsp_word.flow_bytes);
            end
         end
         if (start && !busy) expected_rsp.push_back(count_frame(req_word));
      end
   end
endmodule

// File: tb/ipv4_source_flow_counter_tb.sv
// Top of the IPv4 source flow counter testbench: clock, reset, request stimulus
// and verdict. Depends on isfc_pkg, the block and ipv4_source_flow_counter_checker.
`timescale 1ns / 1ps
module ipv4_source_flow_counter_tb;
   import isfc_pkg::*;

   localparam int FLOWS       = 128;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   logic    quiet_tail;

   // A small pool of source addresses makes repeat hits common; the pool is
   // refreshed now and then so that the table eventually fills.
   logic [31:0] source_pool [8];

   ipv4_source_flow_counter #(.MAX_FLOWS(FLOWS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   ipv4_source_flow_counter_checker #(.MAX_FLOWS(FLOWS)) i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog bounds the run even if the block stops answering.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL ipv4_source_flow_counter");
            $finish;
         end
      end
   end

   // Present one word and hold start until the block takes it. The word is
   // accepted at the edge where start is high and busy is low; the task returns
   // once busy is low again, and the next word (or a low start) is set up at that edge.
   task automatic send_word(req_type w);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic req_type make_frame(logic [15:0] len, logic [15:0] otype,
                                          logic [15:0] itype, logic [31:0] su,
                                          logic [31:0] st);
      req_type w;
      w.frame_length    = len;
      w.outer_type      = otype;
      w.tag_inner_type  = itype;
      w.source_untagged = su;
      w.source_tagged   = st;
      return w;
   endfunction

   // Random frame: mostly IPv4, untagged or single-tagged, with lengths
   // clustered around the short and truncated boundaries, plus noise.
   function automatic req_type random_frame();
      req_type w;
      int pick;
      w = make_frame(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         case ($urandom_range(0, 2))
            0: w.outer_type = ETYPE_IPV4;
            1: begin
               w.outer_type = ETYPE_CVLAN;
               w.tag_inner_type = ($urandom_range(0, 5) == 0) ? ETYPE_CVLAN : ETYPE_IPV4;
            end
            default: begin
               w.outer_type = ETYPE_SVLAN;
               w.tag_inner_type = ETYPE_IPV4;
            end
         endcase
         w.source_untagged = source_pool[$urandom_range(0, 7)];
         w.source_tagged   = source_pool[$urandom_range(0, 7)];
         case ($urandom_range(0, 3))
            0: w.frame_length = 16'($urandom_range(0, 45));
            1: w.frame_length = 16'($urandom_range(46, 1518));
            default: w.frame_length = 16'($urandom_range(60, 200));
         endcase
      end else if (pick == 8) begin
         w.outer_type = ETYPE_IPV4;
      end
      return w;
   endfunction

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      quiet_tail = 1'b0;
      for (int i = 0; i < 8; i++) source_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: short frames, tag boundaries, non-IPv4, truncated
      // headers, field extremes and a double tag.
      send_word(make_frame(16'd0, ETYPE_IPV4, 16'h0, 32'h0, 32'h0));
      send_word(make_frame(16'd13, ETYPE_IPV4, 16'h0, 32'h1, 32'h1));
      send_word(make_frame(16'd14, ETYPE_IPV4, 16'h0, 32'hFFFF_FFFF, 32'h0));
      send_word(make_frame(16'd17, ETYPE_CVLAN, ETYPE_IPV4, 32'h0, 32'h5));
      send_word(make_frame(16'd18, ETYPE_SVLAN, ETYPE_IPV4, 32'h0, 32'h5));
      send_word(make_frame(16'd33, ETYPE_IPV4, 16'h0, 32'hA, 32'hB));
      send_word(make_frame(16'd34, ETYPE_IPV4, 16'h0, 32'hA, 32'hB));
      send_word(make_frame(16'd37, ETYPE_CVLAN, ETYPE_IPV4, 32'hA, 32'hB));
      send_word(make_frame(16'd38, ETYPE_CVLAN, ETYPE_IPV4, 32'hA, 32'hB));
      send_word(make_frame(16'hFFFF, ETYPE_IPV4, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_frame(16'hFFFF, ETYPE_SVLAN, ETYPE_IPV4, 32'h0, 32'hFFFF_FFFF));
      send_word(make_frame(16'd64, 16'h86DD, ETYPE_IPV4, 32'hC, 32'hD));
      send_word(make_frame(16'd64, ETYPE_CVLAN, ETYPE_CVLAN, 32'hC, 32'hD));
      send_word(make_frame(16'd64, ETYPE_CVLAN, 16'hFFFF, 32'hC, 32'hD));
      send_word(make_frame(16'd64, 16'hFFFF, 16'h0, 32'hC, 32'hD));
      send_word(make_frame(16'd64, ETYPE_IPV4, 16'h0, 32'h0, 32'h0));

      // Random words. Refreshing the address pool adds new flows, so the
      // table fills and later words also exercise the table-full case.
      for (int n = 0; n < 500; n++) begin
         if ($urandom_range(0, 9) == 0) source_pool[$urandom_range(0, 7)] = $urandom;
         if (n > 440) quiet_tail = 1'b1;
         send_word(random_frame());
      end
      start <= 1'b0;

      // Drain: let the checker record the last word, wait until every word
      // has its response, then let the block settle before the verdict.
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (FLOWS + 10) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS ipv4_source_flow_counter");
      end else begin
         $display("FAIL ipv4_source_flow_counter");
      end
      $finish;
   end
endmodule
